>>> rtl/cdff_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the clock display frame formatter.
// Used by every module in the rtl folder; depends on nothing else.
package cdff_pkg;

  // Command codes carried in the opcode field.
  localparam logic [1:0] OP_SHOW        = 2'd0;
  localparam logic [1:0] OP_CLEAR_BOTH  = 2'd1;
  localparam logic [1:0] OP_CLEAR_LEFT  = 2'd2;
  localparam logic [1:0] OP_CLEAR_RIGHT = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_BIT_HALF_PERIOD     = 1'b0;
  localparam logic CFG_ENABLE_PULSE_LENGTH = 1'b1;

  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [15:0] BIT_HALF_PERIOD_RESET     = 16'd100;
  localparam logic [23:0] ENABLE_PULSE_LENGTH_RESET = 24'd1000000;

  // Default depth of the command queue between the front and back halves.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Segment patterns, ABCDEFGP with the point in bit 0.
  localparam logic [7:0] BLANK_PATTERN = 8'h00;
  localparam logic [7:0] POINT_BIT     = 8'b0000_0001;
  localparam logic [6:0] MAX_PAIR      = 7'd99;
  localparam logic [3:0] DIGIT_BASE    = 4'd10;

  // Number of drive words per command.
  localparam int unsigned WORDS_PER_FRAME = 4;
  localparam int unsigned WORD_IDX_W      = $clog2(WORDS_PER_FRAME);

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] left_value;
    logic [6:0] right_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] drive_word;
    logic        last_word;
    logic        pulse_left;
    logic        pulse_right;
  } out_item_t;

  // One classified command: four patterns, left tens first, plus enable flags.
  typedef struct packed {
    logic [WORDS_PER_FRAME-1:0][7:0] pats;
    logic                            pulse_left;
    logic                            pulse_right;
  } frame_t;

  // Seven-segment pattern of one decimal digit.
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] p;
    unique case (digit)
      4'd0:    p = 8'hFC;
      4'd1:    p = 8'h60;
      4'd2:    p = 8'hDA;
      4'd3:    p = 8'hF2;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'hB6;
      4'd6:    p = 8'hBE;
      4'd7:    p = 8'hE0;
      4'd8:    p = 8'hFE;
      4'd9:    p = 8'hF6;
      default: p = BLANK_PATTERN;
    endcase
    return p;
  endfunction

  // Interleave a pattern with its complement: bit 2i+1 is p[i], bit 2i is ~p[i].
  function automatic logic [15:0] make_word(input logic [7:0] pat);
    logic [15:0] w;
    for (int i = 0; i < 8; i++) begin
      w[2*i+1] = pat[i];
      w[2*i]   = ~pat[i];
    end
    return w;
  endfunction

endpackage

>>> rtl/cdff_front.sv
`timescale 1ns / 1ps
// Front half: saturates the pair values, splits them into digits and builds
// the four segment patterns of a frame. Depends on cdff_pkg.
module cdff_front import cdff_pkg::*; (
  input  in_item_t cmd,
  output frame_t   frame
);

  logic [6:0]  left_sat;
  logic [6:0]  right_sat;
  logic [14:0] left_prod;
  logic [14:0] right_prod;
  logic [3:0]  left_tens;
  logic [3:0]  right_tens;
  logic [3:0]  left_ones;
  logic [3:0]  right_ones;
  logic [6:0]  left_tens_x10;
  logic [6:0]  right_tens_x10;
  logic        colon;

  // Saturate values above ninety-nine.
  assign left_sat  = (cmd.left_value  > MAX_PAIR) ? MAX_PAIR : cmd.left_value;
  assign right_sat = (cmd.right_value > MAX_PAIR) ? MAX_PAIR : cmd.right_value;

  // Divide by ten through the reciprocal 205/2048, exact for values below 1029.
  assign left_prod  = 15'(left_sat)  * 15'd205;
  assign right_prod = 15'(right_sat) * 15'd205;
  assign left_tens  = left_prod[14:11];
  assign right_tens = right_prod[14:11];

  // The remainder follows from the quotient.
  assign left_tens_x10  = 7'(left_tens)  * 7'(DIGIT_BASE);
  assign right_tens_x10 = 7'(right_tens) * 7'(DIGIT_BASE);
  assign left_ones      = 4'(left_sat  - left_tens_x10);
  assign right_ones     = 4'(right_sat - right_tens_x10);

  // A nonzero left value forces both right digits on and lights the colon.
  assign colon = (left_sat != 7'd0);

  // Pattern selection per opcode, with leading zero blanking.
  always_comb begin
    frame = '0;
    if (cmd.opcode == OP_SHOW) begin
      if (left_tens != 4'd0) begin
        frame.pats[0] = seg_pattern(left_tens);
        frame.pats[1] = seg_pattern(left_ones);
      end else begin
        frame.pats[0] = BLANK_PATTERN;
        frame.pats[1] = (left_ones != 4'd0) ? seg_pattern(left_ones) : BLANK_PATTERN;
      end
      if (colon || (right_tens != 4'd0)) begin
        frame.pats[2] = seg_pattern(right_tens);
        frame.pats[3] = seg_pattern(right_ones) | (colon ? POINT_BIT : BLANK_PATTERN);
      end else begin
        frame.pats[2] = BLANK_PATTERN;
        frame.pats[3] = (right_ones != 4'd0) ? seg_pattern(right_ones) : BLANK_PATTERN;
      end
      frame.pulse_left  = 1'b1;
      frame.pulse_right = 1'b1;
    end else begin
      frame.pats        = {WORDS_PER_FRAME{BLANK_PATTERN}};
      frame.pulse_left  = (cmd.opcode == OP_CLEAR_BOTH) || (cmd.opcode == OP_CLEAR_LEFT);
      frame.pulse_right = (cmd.opcode == OP_CLEAR_BOTH) || (cmd.opcode == OP_CLEAR_RIGHT);
    end
  end

endmodule

>>> rtl/cdff_queue.sv
`timescale 1ns / 1ps
// Short frame queue between the front and back halves, so each can stall alone.
// Depends on cdff_pkg.
module cdff_queue import cdff_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_frame,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output frame_t head_frame
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_t            entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_frame = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("back half popped an empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("fill count missed a push");
`endif

endmodule

>>> rtl/cdff_back.sv
`timescale 1ns / 1ps
// Back half: walks the four patterns of the head frame and emits one drive word
// per cycle, while a frame is queued and the output is not stalled, into an output register. Depends on cdff_pkg.
module cdff_back import cdff_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  frame_t    head_frame,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [WORD_IDX_W-1:0] word_idx;
  logic                  load;
  logic                  is_last;

  // The output register takes a new word whenever a frame is queued and the register is empty or being drained.
  assign load    = head_valid && (!out_valid || out_ready);
  assign is_last = (word_idx == WORD_IDX_W'(WORDS_PER_FRAME - 1));
  assign pop     = load && is_last;

  // Word counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        word_idx  <= is_last ? '0 : word_idx + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_item.drive_word  <= make_word(head_frame.pats[word_idx]);
      out_item.last_word   <= is_last;
      out_item.pulse_left  <= is_last && head_frame.pulse_left;
      out_item.pulse_right <= is_last && head_frame.pulse_right;
    end
  end

`ifndef ASSERT_OFF
  a_pulse_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.last_word) |-> (!out_item.pulse_left && !out_item.pulse_right))
    else $error("enable pulse flagged on a word that is not the last");

  a_pop_wraps: assert property (@(posedge clk) disable iff (rst)
    pop |=> (word_idx == '0))
    else $error("word counter did not wrap after a frame");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("waiting drive word changed before its transaction");
`endif

endmodule

>>> rtl/clock_display_frame_formatter.sv
`timescale 1ns / 1ps
// Clock display frame formatter: one command in, four drive words out.
// An accepted command is written into the queue; its words are then registered
// in the back half's output register. Throughput: one word per cycle when the
// output is not stalled, set by the single output register the back half fills
// one word at a time; the queue takes new commands while earlier ones drain.
// Reset (synchronous, active high) empties the queue and output register and
// returns the timing registers to 100 and 1000000.
module clock_display_frame_formatter import cdff_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  frame_t      front_frame;
  frame_t      head_frame;
  logic        queue_full;
  logic        head_valid;
  logic        pop;
  logic [15:0] bit_half_period;
  logic [23:0] enable_pulse_length;

  // Timing registers for the serial shifter and enable pulse stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_half_period     <= BIT_HALF_PERIOD_RESET;
      enable_pulse_length <= ENABLE_PULSE_LENGTH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BIT_HALF_PERIOD) begin
        bit_half_period <= cfg_wdata[15:0];
      end
      if (cfg_index == CFG_ENABLE_PULSE_LENGTH) begin
        enable_pulse_length <= cfg_wdata[23:0];
      end
    end
  end

  assign in_ready = !queue_full;

  // Classify the incoming command.
  cdff_front u_front (
    .cmd   (in_item),
    .frame (front_frame)
  );

  // Decouple front and back.
  cdff_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_frame (front_frame),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_frame (head_frame)
  );

  // Emit the drive words.
  cdff_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_frame (head_frame),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

>>> sim/clock_display_frame_formatter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the clock display frame formatter: directed edge-case
// commands, then random traffic with random stalls. Depends on rtl/cdff_pkg.sv and the RTL.
module clock_display_frame_formatter_tb;
  import cdff_pkg::*;

  // Four drive words of one command, left tens first.
  typedef out_item_t [0:3] frame_words_t;

  // One row of the directed table; when literal is set the words are typed in.
  typedef struct packed {
    in_item_t        cmd;
    logic            literal;
    logic [0:3][15:0] words;
    logic            pl;
    logic            pr;
  } stim_row_t;

  localparam logic [0:3][15:0] ALL_BLANK = {4{16'h5555}};
  localparam logic [0:3][15:0] ALL_NINES = {16'hAA69, 16'hAA69, 16'hAA69, 16'hAA6A};
  localparam int               NUM_ROWS  = 22;
  localparam int               RANDOM_PER_PHASE = 40;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Expected drive words, oldest first.
  out_item_t expected_words[$];

  // Local copy of the timing registers; they do not change any drive word.
  logic [15:0] half_period_shadow;
  logic [23:0] pulse_len_shadow;

  int  fail_count;
  int  commands_sent;
  int  words_checked;
  bit  no_gaps;
  bit  long_hold_req;
  int  stall_left;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{'{OP_SHOW,        7'd0,   7'd0},   1'b1, ALL_BLANK, 1'b1, 1'b1},
    '{'{OP_SHOW,        7'd99,  7'd99},  1'b1, ALL_NINES, 1'b1, 1'b1},
    '{'{OP_SHOW,        7'd127, 7'd127}, 1'b1, ALL_NINES, 1'b1, 1'b1},
    '{'{OP_SHOW,        7'd100, 7'd0},   1'b0, '0,        1'b0, 1'b0},
    '{'{OP_CLEAR_BOTH,  7'd0,   7'd0},   1'b1, ALL_BLANK, 1'b1, 1'b1},
    '{'{OP_CLEAR_LEFT,  7'd0,   7'd0},   1'b1, ALL_BLANK, 1'b1, 1'b0},
    '{'{OP_CLEAR_RIGHT, 7'd0,   7'd0},   1'b1, ALL_BLANK, 1'b0, 1'b1},
    '{'{OP_CLEAR_BOTH,  7'd127, 7'd127}, 1'b1, ALL_BLANK, 1'b1, 1'b1},
    '{'{OP_CLEAR_LEFT,  7'd127, 7'd0},   1'b1, ALL_BLANK, 1'b1, 1'b0},
    '{'{OP_CLEAR_RIGHT, 7'd0,   7'd127}, 1'b1, ALL_BLANK, 1'b0, 1'b1},
    '{'{OP_SHOW,        7'd0,   7'd5},   1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd0,   7'd45},  1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd0,   7'd10},  1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd5,   7'd0},   1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd10,  7'd7},   1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd0,   7'd99},  1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd99,  7'd0},   1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd0,   7'd100}, 1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd1,   7'd1},   1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd12,  7'd34},  1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd56,  7'd78},  1'b0, '0,        1'b0, 1'b0},
    '{'{OP_SHOW,        7'd90,  7'd64},  1'b0, '0,        1'b0, 1'b0}
  };

  clock_display_frame_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Segment pattern of one decimal digit, ABCDEFGP with the point in bit 0.
  function automatic logic [7:0] digit_segments(input logic [3:0] digit);
    logic [7:0] lut [10];
    lut = '{8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6};
    return lut[digit];
  endfunction

  // Each pattern bit becomes a pair: the bit itself above its complement.
  function automatic logic [15:0] pair_encode(input logic [7:0] pat);
    logic [15:0] w;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w = w | (16'({pat[i], ~pat[i]}) << (2 * i));
    end
    return w;
  endfunction

  // Drive words that one command should produce.
  function automatic frame_words_t predict_frame(input in_item_t cmd);
    logic [7:0]   pats [4];
    logic [6:0]   val;
    logic [3:0]   tens;
    logic [3:0]   ones;
    bit           colon;
    bit           pl;
    bit           pr;
    frame_words_t fw;
    colon = 1'b0;
    for (int k = 0; k < 4; k++) begin
      pats[k] = BLANK_PATTERN;
    end
    if (cmd.opcode == OP_SHOW) begin
      for (int p = 0; p < 2; p++) begin
        val = (p == 0) ? cmd.left_value : cmd.right_value;
        if (val > MAX_PAIR) begin
          val = MAX_PAIR;
        end
        tens = 4'(val / 10);
        ones = 4'(val % 10);
        // Once a nonzero left value has been shown, the right pair is never blanked.
        if (colon || tens != 0) begin
          pats[2*p]   = digit_segments(tens);
          pats[2*p+1] = digit_segments(ones) | (colon ? POINT_BIT : BLANK_PATTERN);
        end else if (ones != 0) begin
          pats[2*p+1] = digit_segments(ones) | (colon ? POINT_BIT : BLANK_PATTERN);
        end
        if (val != 0) begin
          colon = 1'b1;
        end
      end
      pl = 1'b1;
      pr = 1'b1;
    end else begin
      pl = (cmd.opcode == OP_CLEAR_BOTH) || (cmd.opcode == OP_CLEAR_LEFT);
      pr = (cmd.opcode == OP_CLEAR_BOTH) || (cmd.opcode == OP_CLEAR_RIGHT);
    end
    for (int k = 0; k < 4; k++) begin
      fw[k].drive_word  = pair_encode(pats[k]);
      fw[k].last_word   = (k == 3);
      fw[k].pulse_left  = (k == 3) ? pl : 1'b0;
      fw[k].pulse_right = (k == 3) ? pr : 1'b0;
    end
    return fw;
  endfunction

  // Idle length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 25);
  endfunction

  // Pair value biased toward blanking and saturation corners.
  function automatic logic [6:0] random_pair_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return 7'd0;
    end else if (r < 35) begin
      return 7'($urandom_range(1, 9));
    end else if (r < 85) begin
      return 7'($urandom_range(10, 99));
    end
    return 7'($urandom_range(100, 127));
  endfunction

  function automatic in_item_t random_command();
    in_item_t c;
    c.opcode      = ($urandom_range(0, 99) < 70) ? OP_SHOW
                    : 2'($urandom_range(OP_CLEAR_BOTH, OP_CLEAR_RIGHT));
    c.left_value  = random_pair_value();
    c.right_value = random_pair_value();
    return c;
  endfunction

  // Offer one command, wait for the transaction, and queue its expected words.
  // Called and returns at a falling edge; valid stays high unless a gap follows.
  task automatic offer_command(input in_item_t cmd, input bit literal,
                               input frame_words_t literal_words);
    int           gap;
    frame_words_t fw;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      in_item  = in_item_t'(16'($urandom));
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = cmd;
    do @(posedge clk); while (!in_ready);
    fw = literal ? literal_words : predict_frame(cmd);
    for (int k = 0; k < 4; k++) begin
      expected_words.push_back(fw[k]);
    end
    commands_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected word has been seen, plus a margin.
  task automatic drain_frames();
    in_valid = 1'b0;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    if (idx == CFG_BIT_HALF_PERIOD) begin
      half_period_shadow = data[15:0];
    end else begin
      pulse_len_shadow = data;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Clock generator.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        stall_left    = 80;
        long_hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready  = 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready  = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Compare every output transaction against the oldest expected word.
  always @(posedge clk) begin
    out_item_t exp_word;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected drive word %h with nothing expected", out_item.drive_word);
        fail_count++;
      end else begin
        exp_word = expected_words.pop_front();
        words_checked++;
        if (out_item.drive_word !== exp_word.drive_word) begin
          $error("drive_word mismatch: expected %h, actual %h",
                 exp_word.drive_word, out_item.drive_word);
          fail_count++;
        end
        if (out_item.last_word !== exp_word.last_word) begin
          $error("last_word mismatch: expected %b, actual %b",
                 exp_word.last_word, out_item.last_word);
          fail_count++;
        end
        if (out_item.pulse_left !== exp_word.pulse_left) begin
          $error("pulse_left mismatch: expected %b, actual %b",
                 exp_word.pulse_left, out_item.pulse_left);
          fail_count++;
        end
        if (out_item.pulse_right !== exp_word.pulse_right) begin
          $error("pulse_right mismatch: expected %b, actual %b",
                 exp_word.pulse_right, out_item.pulse_right);
          fail_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    frame_words_t fw;
    rst                = 1'b1;
    in_valid           = 1'b0;
    in_item            = '0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_BIT_HALF_PERIOD;
    cfg_wdata          = '0;
    half_period_shadow = BIT_HALF_PERIOD_RESET;
    pulse_len_shadow   = ENABLE_PULSE_LENGTH_RESET;
    fail_count         = 0;
    commands_sent      = 0;
    words_checked      = 0;
    no_gaps            = 1'b0;
    long_hold_req      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Timing settings of one, then the directed table.
    write_reg(CFG_BIT_HALF_PERIOD, 24'd1);
    write_reg(CFG_ENABLE_PULSE_LENGTH, 24'd1);
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int k = 0; k < 4; k++) begin
        fw[k].drive_word  = directed_rows[r].words[k];
        fw[k].last_word   = (k == 3);
        fw[k].pulse_left  = (k == 3) ? directed_rows[r].pl : 1'b0;
        fw[k].pulse_right = (k == 3) ? directed_rows[r].pr : 1'b0;
      end
      offer_command(directed_rows[r].cmd, directed_rows[r].literal, fw);
    end
    drain_frames();

    // Largest settings; the first stretch runs back to back under a long output stall.
    write_reg(CFG_BIT_HALF_PERIOD, 24'hFF_FFFF);
    write_reg(CFG_ENABLE_PULSE_LENGTH, 24'hFF_FFFF);
    no_gaps       = 1'b1;
    long_hold_req = 1'b1;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      if (n == 20) begin
        no_gaps = 1'b0;
      end
      offer_command(random_command(), 1'b0, '0);
    end
    drain_frames();

    // Mid-range random settings, random traffic with random idling.
    write_reg(CFG_BIT_HALF_PERIOD, 24'($urandom_range(2, 65534)));
    write_reg(CFG_ENABLE_PULSE_LENGTH, 24'($urandom_range(2, 16777214)));
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      offer_command(random_command(), 1'b0, '0);
    end
    drain_frames();

    $display("Ran %0d commands and checked %0d drive words across three timing settings,",
             commands_sent, words_checked);
    $display("covering all opcodes, blanking, colon, saturation and a long output stall.");
    if (fail_count == 0) begin
      $display("clock_display_frame_formatter_tb OK");
    end else begin
      $display("clock_display_frame_formatter_tb NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("clock_display_frame_formatter_tb NOT OK");
    $finish;
  end

endmodule
